// ===== sv/assert_macros.svh =====
// Assertion macros used by the densifier RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies another one on the next clock edge.
`define ASSERT_NEXT(label, clk, rst, cond, nxt, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) else $error(msg);

`endif

// ===== sv/ccd_pkg.sv =====
// Types and constants of the closed contour densifier.
`timescale 1ns / 1ps
package ccd_pkg;
  localparam int COORD_W = 32;
  localparam int STEP_W  = 31;
  localparam int MAG_W   = 33;
  localparam int PROD_W  = 66;
  localparam int SQ_W    = 74;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               ins;
  } ccd_res_t;
endpackage

// ===== sv/closed_contour_densifier.sv =====
// Closed contour densifier: drops repeated points, inserts evenly spaced points.
// A kept point holds the input while it runs the difference, three squarings, a search for
// the insert count n, two divides of the 33-bit magnitudes by n+1, and n emits of inserts.
// A last point adds its closing segment; a first or dropped point goes straight to the flush.
// Throughput: one item at a time; a result is held one slot back so the last one carries last.
// Reset (rst, synchronous, active high) clears step_length, contour state and valid flags.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module closed_contour_densifier #(
  parameter int MAX_INSERT = 31
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [30:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_x,
  input  logic [31:0] in_y,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_x,
  output logic [31:0] out_y,
  output logic        out_inserted,
  output logic        out_last
);
  localparam int NW = $clog2(MAX_INSERT + 1);
  localparam int DW = NW + 1;
  localparam int CW = 6;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIFF  = 4'd1;
  localparam logic [3:0] S_MX    = 4'd2;
  localparam logic [3:0] S_MY    = 4'd3;
  localparam logic [3:0] S_SS    = 4'd4;
  localparam logic [3:0] S_SINIT = 4'd5;
  localparam logic [3:0] S_SRCH  = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_EINIT = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;
  localparam logic [3:0] S_SEND  = 4'd10;
  localparam logic [3:0] S_FLUSH = 4'd11;

  logic [3:0] state;
  logic [ccd_pkg::STEP_W-1:0] step_length;
  logic [31:0] first_x, first_y, prev_x, prev_y;
  logic have_first;
  logic last_r, closing;
  logic [31:0] ax, ay, bx, by;
  logic [ccd_pkg::MAG_W-1:0] mx, my;
  logic sx, sy;
  logic [ccd_pkg::PROD_W-1:0] prod;
  logic [ccd_pkg::PROD_W-1:0] dsum;
  logic [61:0] s2;
  logic [ccd_pkg::SQ_W-1:0] sq, inc;
  logic [NW-1:0] n, k;
  logic [ccd_pkg::MAG_W-1:0] dvq;
  logic [DW-1:0] drem;
  logic [CW-1:0] cnt;
  logic dsel;
  logic [ccd_pkg::MAG_W-1:0] qdx, qdy;
  logic [DW-1:0] rdx, rdy, rx, ry;
  logic [ccd_pkg::MAG_W:0] qx, qy;
  logic pend_valid;
  ccd_pkg::ccd_res_t pend;

  // Combinational helpers
  logic signed [32:0] dxw, dyw;
  logic [DW-1:0] div;
  logic [DW:0] dtrial, nrx, nry;
  logic dbit, cx, cy;
  logic [ccd_pkg::MAG_W:0] nqx, nqy;
  logic [31:0] ex, ey;
  logic out_free, can_push, push, load_out;
  ccd_pkg::ccd_res_t push_data;
  logic [ccd_pkg::MAG_W-1:0] mul_a, mul_b;

  assign dxw = $signed({bx[31], bx}) - $signed({ax[31], ax});
  assign dyw = $signed({by[31], by}) - $signed({ay[31], ay});
  assign div = DW'({1'b0, n}) + DW'(1);
  assign dtrial = {drem, dvq[ccd_pkg::MAG_W-1]};
  assign dbit = dtrial >= {1'b0, div};
  assign nrx = {1'b0, rx} + {1'b0, rdx};
  assign nry = {1'b0, ry} + {1'b0, rdy};
  assign cx = nrx >= {1'b0, div};
  assign cy = nry >= {1'b0, div};
  assign nqx = qx + {1'b0, qdx} + {{ccd_pkg::MAG_W{1'b0}}, cx};
  assign nqy = qy + {1'b0, qdy} + {{ccd_pkg::MAG_W{1'b0}}, cy};
  assign ex = sx ? ax - nqx[31:0] : ax + nqx[31:0];
  assign ey = sy ? ay - nqy[31:0] : ay + nqy[31:0];
  assign out_free = !out_valid || out_ready;
  assign can_push = !pend_valid || out_free;
  assign load_out = pend_valid && (push || (state == S_FLUSH && out_free));
  assign in_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    push = 1'b0;
    push_data = '{x: bx, y: by, ins: 1'b0};
    mul_a = mx;
    mul_b = mx;
    unique case (state)
      S_IDLE: begin
        push = in_valid && !have_first;
        push_data = '{x: in_x, y: in_y, ins: 1'b0};
      end
      S_MY: begin
        mul_a = my;
        mul_b = my;
      end
      S_SS: begin
        mul_a = {2'b0, step_length};
        mul_b = {2'b0, step_length};
      end
      S_EMIT: begin
        push = can_push;
        push_data = '{x: ex, y: ey, ins: 1'b1};
      end
      S_SEND: push = !closing && can_push;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step_length <= '0;
      first_x <= '0;
      first_y <= '0;
      prev_x <= '0;
      prev_y <= '0;
      have_first <= 1'b0;
      n <= '0;
      pend_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        step_length <= cfg_data;
      end
      prod <= mul_a * mul_b;

      // Output slot: loaded from the hold slot, else drained by the consumer.
      if (push) begin
        pend <= push_data;
        pend_valid <= 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
        out_x <= pend.x;
        out_y <= pend.y;
        out_inserted <= pend.ins;
        out_last <= (state == S_FLUSH) && last_r;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            last_r <= in_last;
            have_first <= !in_last;
            if (!have_first) begin
              first_x <= in_x;
              first_y <= in_y;
              prev_x <= in_x;
              prev_y <= in_y;
              state <= S_FLUSH;
            end else if (!(in_x == prev_x && in_y == prev_y) &&
                         !(in_last && in_x == first_x && in_y == first_y)) begin
              ax <= prev_x;
              ay <= prev_y;
              bx <= in_x;
              by <= in_y;
              closing <= 1'b0;
              state <= S_DIFF;
            end else if (in_last) begin
              ax <= prev_x;
              ay <= prev_y;
              bx <= first_x;
              by <= first_y;
              closing <= 1'b1;
              state <= S_DIFF;
            end else begin
              state <= S_FLUSH;
            end
          end
        end
        S_DIFF: begin
          sx <= dxw[32];
          sy <= dyw[32];
          mx <= dxw[32] ? 33'(~dxw + 33'sd1) : 33'(dxw);
          my <= dyw[32] ? 33'(~dyw + 33'sd1) : 33'(dyw);
          state <= S_MX;
        end
        S_MX: state <= S_MY;
        S_MY: begin
          dsum <= prod;
          state <= S_SS;
        end
        S_SS: begin
          dsum <= dsum + prod;
          state <= S_SINIT;
        end
        S_SINIT: begin
          s2 <= prod[61:0];
          sq <= {8'b0, prod};
          inc <= {8'b0, prod} + {7'b0, prod, 1'b0};
          n <= '0;
          state <= (step_length == '0) ? S_SEND : S_SRCH;
        end
        S_SRCH: begin
          // Count up while (n+1)^2 * step^2 stays within the squared length.
          if (n != NW'(MAX_INSERT) && sq <= {8'b0, dsum}) begin
            n <= n + NW'(1);
            sq <= sq + inc;
            inc <= inc + {11'b0, s2, 1'b0};
          end else if (n == '0) begin
            state <= S_SEND;
          end else begin
            dvq <= mx;
            drem <= '0;
            cnt <= '0;
            dsel <= 1'b0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (cnt == CW'(ccd_pkg::MAG_W - 1)) begin
            cnt <= '0;
            if (!dsel) begin
              qdx <= {dvq[ccd_pkg::MAG_W-2:0], dbit};
              rdx <= dbit ? DW'(dtrial - {1'b0, div}) : dtrial[DW-1:0];
              dvq <= my;
              drem <= '0;
              dsel <= 1'b1;
            end else begin
              qdy <= {dvq[ccd_pkg::MAG_W-2:0], dbit};
              rdy <= dbit ? DW'(dtrial - {1'b0, div}) : dtrial[DW-1:0];
              state <= S_EINIT;
            end
          end else begin
            cnt <= cnt + CW'(1);
            dvq <= {dvq[ccd_pkg::MAG_W-2:0], dbit};
            drem <= dbit ? DW'(dtrial - {1'b0, div}) : dtrial[DW-1:0];
          end
        end
        S_EINIT: begin
          // Start each remainder at half the divisor for round-half-away.
          qx <= '0;
          qy <= '0;
          rx <= div >> 1;
          ry <= div >> 1;
          k <= '0;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (can_push) begin
            qx <= nqx;
            qy <= nqy;
            rx <= cx ? DW'(nrx - {1'b0, div}) : nrx[DW-1:0];
            ry <= cy ? DW'(nry - {1'b0, div}) : nry[DW-1:0];
            k <= k + NW'(1);
            if (k + NW'(1) == n) begin
              state <= S_SEND;
            end
          end
        end
        S_SEND: begin
          if (closing) begin
            state <= S_FLUSH;
          end else if (can_push) begin
            prev_x <= bx;
            prev_y <= by;
            if (last_r) begin
              ax <= bx;
              ay <= by;
              bx <= first_x;
              by <= first_y;
              closing <= 1'b1;
              state <= S_DIFF;
            end else begin
              state <= S_FLUSH;
            end
          end
        end
        S_FLUSH: begin
          // Release the held result, marked last if the contour ends here.
          if (!pend_valid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            pend_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_CLK(a_idle_empty, clk, rst, !in_ready || !pend_valid, "held item while idle")
  `ASSERT_NEXT(a_accept_busy, clk, rst, in_valid && in_ready, state != S_IDLE, "accept not taken")
  `ASSERT_CLK(a_emit_count, clk, rst, state != S_EMIT || k < n, "emit past count")
  `ASSERT_CLK(a_n_bound, clk, rst, n <= NW'(MAX_INSERT), "insert count above limit")
endmodule
